@@ sv/tcd_pkg.sv @@
`timescale 1ns / 1ps

package tcd_pkg;

  localparam int unsigned TEMP_W = 16;
  localparam int unsigned ERR_W = 17;
  localparam int unsigned HELD_W = 4;
  localparam int unsigned PC_W = 3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SETPOINT = 2'd0;
  localparam logic [1:0] REG_ON_THR = 2'd1;
  localparam logic [1:0] REG_OFF_THR = 2'd2;
  localparam logic [1:0] REG_TREND_THR = 2'd3;

  localparam logic [1:0] TREND_STABLE = 2'b00;
  localparam logic [1:0] TREND_RISE = 2'b01;
  localparam logic [1:0] TREND_FALL = 2'b11;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_IDLE = 2'd2
  } mode_e;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_NO_INPUT  = 3'd1,
    COND_SCAN_MORE = 3'd2,
    COND_DIV_MORE  = 3'd3,
    COND_OUT_BUSY  = 3'd4
  } cond_e;

  // Program step addresses.
  localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [PC_W-1:0] STEP_READ = 3'd1;
  localparam logic [PC_W-1:0] STEP_ACC = 3'd2;
  localparam logic [PC_W-1:0] STEP_OLDEST = 3'd3;
  localparam logic [PC_W-1:0] STEP_TREND = 3'd4;
  localparam logic [PC_W-1:0] STEP_DIV = 3'd5;
  localparam logic [PC_W-1:0] STEP_FIX = 3'd6;
  localparam logic [PC_W-1:0] STEP_OUT = 3'd7;

  typedef struct packed {
    logic in_rdy;
    logic rd_scan;
    logic rd_oldest;
    logic acc_en;
    logic trend_en;
    logic div_load;
    logic div_step;
    logic fix_en;
    logic out_load;
    cond_e cond;
    logic [PC_W-1:0] target;
  } uctrl_t;

  typedef struct packed {
    logic in_valid;
    logic scan_more;
    logic div_more;
    logic out_busy;
  } seq_flags_t;

  function automatic uctrl_t ucode_rom(input logic [PC_W-1:0] pc);
    uctrl_t w;
    w = '{default: '0, cond: COND_NEVER, target: STEP_IDLE};
    unique case (pc)
      STEP_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond = COND_NO_INPUT;
        w.target = STEP_IDLE;
      end
      STEP_READ: w.rd_scan = 1'b1;
      STEP_ACC: begin
        w.acc_en = 1'b1;
        w.cond = COND_SCAN_MORE;
        w.target = STEP_READ;
      end
      STEP_OLDEST: w.rd_oldest = 1'b1;
      STEP_TREND: begin
        w.trend_en = 1'b1;
        w.div_load = 1'b1;
      end
      STEP_DIV: begin
        w.div_step = 1'b1;
        w.cond = COND_DIV_MORE;
        w.target = STEP_DIV;
      end
      STEP_FIX: w.fix_en = 1'b1;
      STEP_OUT: begin
        w.out_load = 1'b1;
        w.cond = COND_OUT_BUSY;
        w.target = STEP_OUT;
      end
      default: w.cond = COND_NEVER;
    endcase
    return w;
  endfunction

endpackage

@@ sv/tcd_seq.sv @@
`timescale 1ns / 1ps

module tcd_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcd_pkg::seq_flags_t   flags_i,
  output tcd_pkg::uctrl_t       ctrl_o
);

  logic [tcd_pkg::PC_W-1:0] pc_q, pc_d;
  tcd_pkg::uctrl_t          word;
  logic                     take_jump;

  assign word = tcd_pkg::ucode_rom(pc_q);
  assign ctrl_o = word;

  always_comb begin
    unique case (word.cond)
      tcd_pkg::COND_NEVER:     take_jump = 1'b0;
      tcd_pkg::COND_NO_INPUT:  take_jump = !flags_i.in_valid;
      tcd_pkg::COND_SCAN_MORE: take_jump = flags_i.scan_more;
      tcd_pkg::COND_DIV_MORE:  take_jump = flags_i.div_more;
      tcd_pkg::COND_OUT_BUSY:  take_jump = flags_i.out_busy;
      default:                 take_jump = 1'b0;
    endcase
  end

  // The last step falls through to address zero by wrap-around.
  assign pc_d = take_jump ? word.target : pc_q + tcd_pkg::PC_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tcd_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ sv/tcd_div.sv @@
`timescale 1ns / 1ps

module tcd_div #(
  parameter int unsigned SUM_W = 20,
  parameter int unsigned CNT_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             step_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic [SUM_W-1:0] quotient_o,
  output logic             last_o
);

  localparam int unsigned ITER_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              ge;

  // Restoring division, one quotient bit per step; quotient bits shift
  // into the dividend register as its bits move out.
  assign shifted = {rem_q, dvd_q[SUM_W-1]};
  assign ge = shifted >= {1'b0, dsr_q};
  assign diff = shifted - {1'b0, dsr_q};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    if (load_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = ITER_W'(SUM_W);
    end else if (step_i) begin
      dvd_d = {dvd_q[SUM_W-2:0], ge};
      rem_d = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      cnt_d = cnt_q - ITER_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = dvd_q;
  assign last_o = cnt_q == ITER_W'(1);

endmodule

@@ sv/thermostat_trend_cooling_decider_top.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   sample_temp_i
// out      output     out_valid_o / out_ready_i average_temp_o, trend_o, temp_error_o,
//                                               cooling_mode_o, samples_held_o
// cfg      input      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// The time an item takes is set by the ring scan (one read and one add per entry
// over the single memory port) and by the bit-serial divider, whose width is
// SUM_W = 16 + clog2(RING_DEPTH+1).
// Reset clears the control state and loads the register defaults; no clearing pass.
// A stalled result sits in the output register while the next item is accepted
// and worked on; only the final load step waits for that register to free up.

module thermostat_trend_cooling_decider_top #(
  parameter int unsigned RING_DEPTH = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] sample_temp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] average_temp_o,
  output logic signed [1:0]  trend_o,
  output logic signed [16:0] temp_error_o,
  output logic [1:0]  cooling_mode_o,
  output logic [3:0]  samples_held_o
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W = tcd_pkg::TEMP_W + CNT_W;

  tcd_pkg::uctrl_t     ctrl;
  tcd_pkg::seq_flags_t flags;

  logic signed [15:0] setpoint_q;
  logic [15:0]        on_thr_q, off_thr_q, trend_thr_q;

  logic [15:0]        ring_mem [RING_DEPTH];
  logic [15:0]        rd_data_q;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;

  logic [AW-1:0]      wr_slot_q, wr_slot_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic               in_acc;
  logic               full;

  logic signed [15:0]    sample_q;
  logic signed [16:0]    err_q;
  logic signed [SUM_W-1:0] acc_q;
  logic [1:0]            trend_q;
  logic                  neg_q;
  logic [15:0]           avg_q;
  logic [SUM_W-1:0]      quotient;
  logic [SUM_W-1:0]      sum_mag;
  logic                  div_last;

  logic signed [16:0] diff;
  logic signed [17:0] trend_thr_s;
  logic signed [17:0] err_ext;
  logic [1:0]         trend_calc;
  logic [1:0]         mode_calc;
  logic               out_busy;
  logic               out_take;
  logic [CNT_W+3:0]   held_ext;

  logic               out_valid_q;
  logic [15:0]        avg_out_q;
  logic [1:0]         trend_out_q;
  logic [16:0]        err_out_q;
  logic [1:0]         mode_out_q;
  logic [3:0]         held_out_q;

  tcd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctrl_o (ctrl)
  );

  tcd_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (ctrl.div_load),
    .step_i    (ctrl.div_step),
    .dividend_i(sum_mag),
    .divisor_i (fill_q),
    .quotient_o(quotient),
    .last_o    (div_last)
  );

  assign in_ready_o = ctrl.in_rdy;
  assign in_acc = in_valid_i && ctrl.in_rdy;
  assign full = fill_q == CNT_W'(RING_DEPTH);
  assign out_busy = out_valid_q && !out_ready_i;
  assign out_take = ctrl.out_load && !out_busy;

  assign flags.in_valid = in_valid_i;
  assign flags.scan_more = scan_q != fill_q;
  assign flags.div_more = !div_last;
  assign flags.out_busy = out_busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= '0;
      on_thr_q <= 16'd32;
      off_thr_q <= 16'd8;
      trend_thr_q <= 16'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcd_pkg::REG_SETPOINT:  setpoint_q <= cfg_data_i;
        tcd_pkg::REG_ON_THR:    on_thr_q <= cfg_data_i;
        tcd_pkg::REG_OFF_THR:   off_thr_q <= cfg_data_i;
        tcd_pkg::REG_TREND_THR: trend_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ring pointers and scan counter.
  always_comb begin
    wr_slot_d = wr_slot_q;
    fill_d = fill_q;
    scan_d = scan_q;
    if (in_acc) begin
      wr_slot_d = (wr_slot_q == AW'(RING_DEPTH - 1)) ? '0 : wr_slot_q + AW'(1);
      fill_d = full ? fill_q : fill_q + CNT_W'(1);
      scan_d = '0;
    end else if (ctrl.rd_scan) begin
      scan_d = scan_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q <= '0;
      fill_q <= '0;
      scan_q <= '0;
    end else begin
      wr_slot_q <= wr_slot_d;
      fill_q <= fill_d;
      scan_q <= scan_d;
    end
  end

  // Once the ring is full the oldest sample sits at the next write slot;
  // before that it is entry zero.
  assign rd_addr = ctrl.rd_oldest ? (full ? wr_slot_q : '0) : scan_q[AW-1:0];
  assign rd_en = ctrl.rd_scan || ctrl.rd_oldest;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring_mem[wr_slot_q] <= sample_temp_i;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  // Trend from the newest sample against the oldest.
  assign diff = {sample_q[15], sample_q} - {rd_data_q[15], rd_data_q};
  assign trend_thr_s = {2'b00, trend_thr_q};

  always_comb begin
    trend_calc = tcd_pkg::TREND_STABLE;
    if (fill_q >= CNT_W'(2)) begin
      if ($signed({diff[16], diff}) > trend_thr_s) begin
        trend_calc = tcd_pkg::TREND_RISE;
      end else if ($signed({diff[16], diff}) < -trend_thr_s) begin
        trend_calc = tcd_pkg::TREND_FALL;
      end
    end
  end

  assign sum_mag = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_temp_i;
      err_q <= {sample_temp_i[15], sample_temp_i} - {setpoint_q[15], setpoint_q};
      acc_q <= '0;
    end else if (ctrl.acc_en) begin
      acc_q <= acc_q + SUM_W'(signed'(rd_data_q));
    end
    if (ctrl.trend_en) begin
      trend_q <= trend_calc;
      neg_q <= acc_q[SUM_W-1];
    end
    if (ctrl.fix_en) begin
      avg_q <= neg_q ? -quotient[15:0] : quotient[15:0];
    end
  end

  // Cooling decision; a falling trend with positive error holds at idle.
  assign err_ext = {err_q[16], err_q};

  always_comb begin
    if (err_ext > signed'({2'b00, on_thr_q})) begin
      mode_calc = tcd_pkg::MODE_ON;
    end else if (err_ext <= signed'({2'b00, off_thr_q})) begin
      mode_calc = tcd_pkg::MODE_OFF;
    end else begin
      mode_calc = tcd_pkg::MODE_IDLE;
    end
    if (trend_q == tcd_pkg::TREND_FALL && err_ext > 18'sd0) begin
      mode_calc = tcd_pkg::MODE_IDLE;
    end
  end

  assign held_ext = {4'b0000, fill_q};

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      avg_out_q <= avg_q;
      trend_out_q <= trend_q;
      err_out_q <= err_q;
      mode_out_q <= mode_calc;
      held_out_q <= held_ext[3:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_temp_o = avg_out_q;
  assign trend_o = trend_out_q;
  assign temp_error_o = err_out_q;
  assign cooling_mode_o = mode_out_q;
  assign samples_held_o = held_out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_slot_q <= AW'(RING_DEPTH - 1))
    else $error("write slot beyond ring depth");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (fill_q == $past(fill_q) + CNT_W'(1)) ||
               (fill_q == CNT_W'(RING_DEPTH) && $past(fill_q) == CNT_W'(RING_DEPTH)))
    else $error("fill count did not advance on an accepted item");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.acc_en |-> scan_q <= fill_q && scan_q != '0)
    else $error("ring scan ran past the held samples");

endmodule
